// ----- hdl/heard_station_cache_macros.svh -----
// Assertion macros used by the checker file of the heard station cache.
`ifndef HEARD_STATION_CACHE_MACROS_SVH
`define HEARD_STATION_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("heard station cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("heard station cache assertion failed");

`endif

// ----- hdl/hsc_pkg.sv -----
// Package with the types and constants of the heard station cache.
package hsc_pkg;

  typedef enum logic [1:0] {
    OUT_ALIAS   = 2'd0,
    OUT_REFRESH = 2'd1,
    OUT_ADDED   = 2'd2,
    OUT_FULL    = 2'd3
  } outcome_e;

  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [31:0] LifetimeReset = 32'd180000;

  localparam logic [39:0] WordRelay = "RELAY";
  localparam logic [39:0] WordEcho  = {"ECHO", 8'h00};
  localparam logic [39:0] WordTrace = "TRACE";
  localparam logic [39:0] WordGate  = {"GATE", 8'h00};
  localparam logic [31:0] WordWide  = "WIDE";

  localparam logic [3:0] LenRelay = 4'd5;
  localparam logic [3:0] LenEcho  = 4'd4;
  localparam logic [3:0] LenTrace = 4'd5;
  localparam logic [3:0] LenGate  = 4'd4;
  localparam logic [3:0] LenWide  = 4'd4;

  typedef struct packed {
    logic load;
    logic scan;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic              is_alias;
    logic              scan_done;
    logic              found;
    logic              free_ok;
    logic [CountW-1:0] expired_count;
  } sts_t;

endpackage

// ----- hdl/hsc_in_if.sv -----
// Input channel carrying one received frame item.
interface hsc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] src_chars_hi;
  logic [7:0]  src_chars_lo;
  logic [3:0]  src_len;
  logic [63:0] digi_chars_hi;
  logic [7:0]  digi_chars_lo;
  logic [3:0]  digi_len;
  logic        digi_valid;
  logic [31:0] now_tick;

  modport source (
    output valid, src_chars_hi, src_chars_lo, src_len,
    output digi_chars_hi, digi_chars_lo, digi_len, digi_valid, now_tick,
    input  ready
  );
  modport sink (
    input  valid, src_chars_hi, src_chars_lo, src_len,
    input  digi_chars_hi, digi_chars_lo, digi_len, digi_valid, now_tick,
    output ready
  );
endinterface

// ----- hdl/hsc_out_if.sv -----
// Output channel carrying one result item.
interface hsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [4:0] expired_count;

  modport source (output valid, outcome, expired_count, input ready);
  modport sink (input valid, outcome, expired_count, output ready);
endinterface

// ----- hdl/hsc_cfg_if.sv -----
// Configuration write channel for the entry lifetime register.
interface hsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hdl/hsc_ctrl.sv -----
// Controller state machine and result register of the heard station cache.
module hsc_ctrl import hsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        outcome_o,
  output logic [CountW-1:0] expired_count_o,
  output cmd_t              cmd_o,
  input  sts_t              sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILTER,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  outcome_e          outcome_q;
  logic [CountW-1:0] count_q;
  logic              out_free;
  logic              out_set;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_set    = ((state_q == ST_FILTER) && sts_i.is_alias && out_free) ||
                      ((state_q == ST_FINISH) && out_free);

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.insert = (state_q == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      outcome_q   <= OUT_ALIAS;
      count_q     <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_FILTER;
          end
        end
        ST_FILTER: begin
          if (!sts_i.is_alias) begin
            state_q <= ST_SCAN;
          end else if (out_free) begin
            outcome_q   <= OUT_ALIAS;
            count_q     <= '0;
            state_q     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            count_q     <= sts_i.expired_count;
            if (sts_i.found) begin
              outcome_q <= OUT_REFRESH;
            end else if (sts_i.free_ok) begin
              outcome_q <= OUT_ADDED;
            end else begin
              outcome_q <= OUT_FULL;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = outcome_q;
  assign expired_count_o = count_q;

endmodule

// ----- hdl/hsc_datapath.sv -----
// Datapath of the heard station cache: key capture, alias filter and slot table.
module hsc_datapath import hsc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ADDR_CHARS  = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic [63:0] src_chars_hi_i,
  input  logic [7:0]  src_chars_lo_i,
  input  logic [3:0]  src_len_i,
  input  logic [63:0] digi_chars_hi_i,
  input  logic [7:0]  digi_chars_lo_i,
  input  logic [3:0]  digi_len_i,
  input  logic        digi_valid_i,
  input  logic [31:0] now_tick_i
);

  localparam int unsigned KeyW = ADDR_CHARS * 8;
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TABLE_DEPTH - 1);
  localparam logic [3:0] LenMax = 4'(ADDR_CHARS);

  logic [KeyW-1:0] mem_addr [TABLE_DEPTH];
  logic [3:0]      mem_len  [TABLE_DEPTH];
  logic [31:0]     mem_tick [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid_q;
  logic [31:0]            lifetime_q;

  logic [KeyW-1:0] key_q, key_d;
  logic [3:0]      len_q, len_d;
  logic [31:0]     now_q;

  logic [71:0] raw;
  logic [3:0]  raw_len;

  logic            rd_active_q;
  logic [IdxW-1:0] rd_cnt_q;
  logic            ev_valid_q;
  logic [IdxW-1:0] ev_idx_q;
  logic [KeyW-1:0] rd_addr_q;
  logic [3:0]      rd_len_q;
  logic [31:0]     rd_tick_q;

  logic              found_q;
  logic              free_ok_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [CountW-1:0] count_q;

  logic        rd_en, ev_en, insert_we;
  logic        slot_v, slot_match, slot_expired, slot_free;
  logic [31:0] age;

  logic [5:0][7:0] head;
  logic            alias_hit;

  function automatic logic prefix_hit(logic [5:0][7:0] c, logic [3:0] len,
                                      logic [39:0] word, logic [3:0] n);
    logic hit;
    hit = (len <= n);
    for (int i = 0; i < 5; i++) begin
      if ((4'(i) < len) && (c[i] != word[39-8*i -: 8])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  always_comb begin
    raw     = digi_valid_i ? {digi_chars_hi_i, digi_chars_lo_i}
                           : {src_chars_hi_i, src_chars_lo_i};
    raw_len = digi_valid_i ? digi_len_i : src_len_i;
    len_d   = (raw_len > LenMax) ? LenMax : raw_len;
    key_d   = '0;
    for (int i = 0; i < ADDR_CHARS; i++) begin
      if (4'(i) < len_d) begin
        key_d[KeyW-1-8*i -: 8] = raw[71-8*i -: 8];
      end
    end
  end

  always_comb begin
    logic wide_hit;
    for (int i = 0; i < 6; i++) begin
      head[i] = key_q[KeyW-1-8*i -: 8];
    end
    wide_hit = (len_q >= LenWide) && ({head[0], head[1], head[2], head[3]} == WordWide) &&
               ((len_q == LenWide) ||
                ((head[4] >= "0") && (head[4] <= "9") &&
                 ((len_q == LenWide + 4'd1) || (head[5] == "-"))));
    alias_hit = prefix_hit(head, len_q, WordRelay, LenRelay) ||
                prefix_hit(head, len_q, WordEcho, LenEcho) ||
                prefix_hit(head, len_q, WordTrace, LenTrace) ||
                prefix_hit(head, len_q, WordGate, LenGate) ||
                wide_hit;
  end

  assign rd_en = cmd_i.scan && rd_active_q;
  assign ev_en = cmd_i.scan && ev_valid_q;
  assign insert_we = cmd_i.insert && !found_q && free_ok_q;

  always_comb begin
    age          = now_q - rd_tick_q;
    slot_v       = valid_q[ev_idx_q];
    slot_match   = slot_v && (rd_len_q == len_q) && (rd_addr_q == key_q);
    slot_expired = slot_v && !slot_match && (age > lifetime_q);
    slot_free    = !slot_v || slot_expired;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_d;
      len_q <= len_d;
      now_q <= now_tick_i;
    end
    if (rd_en) begin
      rd_addr_q <= mem_addr[rd_cnt_q];
      rd_len_q  <= mem_len[rd_cnt_q];
      rd_tick_q <= mem_tick[rd_cnt_q];
    end
    if (insert_we) begin
      mem_addr[free_idx_q] <= key_q;
      mem_len[free_idx_q]  <= len_q;
      mem_tick[free_idx_q] <= now_q;
    end else if (ev_en && slot_match) begin
      mem_tick[ev_idx_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      lifetime_q  <= LifetimeReset;
      rd_active_q <= 1'b0;
      rd_cnt_q    <= '0;
      ev_valid_q  <= 1'b0;
      ev_idx_q    <= '0;
      found_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      free_idx_q  <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        lifetime_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        rd_active_q <= 1'b1;
        rd_cnt_q    <= '0;
        ev_valid_q  <= 1'b0;
        found_q     <= 1'b0;
        free_ok_q   <= 1'b0;
        count_q     <= '0;
      end
      if (cmd_i.scan) begin
        ev_valid_q <= rd_active_q;
        ev_idx_q   <= rd_cnt_q;
        if (rd_active_q) begin
          if (rd_cnt_q == IdxLast) begin
            rd_active_q <= 1'b0;
          end else begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
        end
      end
      if (ev_en) begin
        if (slot_match) begin
          found_q <= 1'b1;
        end
        if (slot_expired) begin
          valid_q[ev_idx_q] <= 1'b0;
          if (count_q != CountMax) begin
            count_q <= count_q + 1'b1;
          end
        end
        if (slot_free && !free_ok_q) begin
          free_ok_q  <= 1'b1;
          free_idx_q <= ev_idx_q;
        end
      end
      if (insert_we) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.is_alias      = alias_hit;
    sts_o.scan_done     = !rd_active_q && !ev_valid_q;
    sts_o.found         = found_q;
    sts_o.free_ok       = free_ok_q;
    sts_o.expired_count = count_q;
  end

endmodule

// ----- hdl/heard_station_cache.sv -----
// Top level of the heard station cache: a bounded table of recently heard stations.
//
// Each input item is one received frame on in_ch. The heard address is the
// digipeater when digi_valid is set and the source otherwise. Aliases give
// outcome 0 with no table pass; any other address starts one pass over the table.
// The pass refreshes an exact match, expires other entries older than the
// lifetime register and then inserts a missing address in the lowest free slot,
// if there is one. Each item gives exactly one result item on out_ch with the
// outcome and the number of entries expired in the pass.
// An alias result is registered in ST_FILTER, any other result in ST_FINISH
// after ST_SCAN has made its serial pass over the slot memory, one slot read
// per cycle. Items are handled one at a time: the next item is accepted only
// when the controller is back in ST_IDLE.
// The lifetime register is written through cfg_ch, which is always ready.
// Reset clears all valid marks and loads the lifetime with 180000 ticks.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver holds a finished pass until it is taken.
module heard_station_cache import hsc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ADDR_CHARS  = 9
) (
  input  logic clk_i,
  input  logic rst_ni,
  hsc_in_if.sink    in_ch,
  hsc_out_if.source out_ch,
  hsc_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  hsc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_o      (in_ch.ready),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .outcome_o       (out_ch.outcome),
    .expired_count_o (out_ch.expired_count),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  hsc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_CHARS  (ADDR_CHARS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_ch.valid),
    .cfg_data_i      (cfg_ch.data),
    .src_chars_hi_i  (in_ch.src_chars_hi),
    .src_chars_lo_i  (in_ch.src_chars_lo),
    .src_len_i       (in_ch.src_len),
    .digi_chars_hi_i (in_ch.digi_chars_hi),
    .digi_chars_lo_i (in_ch.digi_chars_lo),
    .digi_len_i      (in_ch.digi_len),
    .digi_valid_i    (in_ch.digi_valid),
    .now_tick_i      (in_ch.now_tick)
  );

endmodule

// ----- hdl/hsc_checker.sv -----
// Port-level assertion checker of the heard station cache and its bind.
`include "heard_station_cache_macros.svh"

module hsc_checker import hsc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  outcome_i,
  input logic [4:0]  expired_count_i
);

  `HSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `HSC_ASSERT_NOW(a_alias_no_expiry, clk_i, rst_ni,
                  out_valid_i && (outcome_i == OUT_ALIAS), expired_count_i == 5'd0)
  `HSC_ASSERT_NOW(a_count_bound, clk_i, rst_ni, out_valid_i, expired_count_i <= TABLE_DEPTH)
  `HSC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind heard_station_cache hsc_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_hsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .outcome_i       (out_ch.outcome),
  .expired_count_i (out_ch.expired_count)
);
